// ----- rtl/ftj_pkg.sv -----
// ----------------------------------------------------------------------------
// ftj_pkg
// shared types, codes and constants of the floating touch joystick
// ----------------------------------------------------------------------------
package ftj_pkg;

    localparam int COORD_FRAC_BITS_DEF = 4;
    localparam int ID_WIDTH_DEF        = 32;

    localparam int POS_W      = 16;
    localparam int ID_PORT_W  = 32;
    localparam int RADIUS_W   = 10;
    localparam int FIELD_W    = 12;
    localparam int AXIS_W     = 16;
    localparam int AXIS_BITS  = 15;
    localparam int AXIS_FULL  = 32767;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // event codes
    localparam logic [1:0] ACT_PRESS   = 2'd0;
    localparam logic [1:0] ACT_MOVE    = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;

    localparam logic KIND_MOUSE = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_W = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_H = 2'd2;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET  = 10'd80;
    localparam logic [FIELD_W-1:0]  FIELD_W_RESET = 12'd320;
    localparam logic [FIELD_W-1:0]  FIELD_H_RESET = 12'd480;

    typedef enum logic [3:0] {
        ST_IDLE, ST_COORD, ST_DECIDE, ST_DIFF, ST_SQX, ST_SQY, ST_CHECK,
        ST_SQRT, ST_DIV_LOAD, ST_DIV_RUN, ST_COMMIT, ST_DONE
    } state_t;

    typedef enum logic [1:0] {JOB_AX, JOB_AY, JOB_OX, JOB_OY} job_t;

    typedef struct packed {
        logic load;
        logic coord;
        logic press;
        logic release_src;
        logic diff;
        logic sqx;
        logic sqy;
        logic check;
        logic sqrt_step;
        logic div_load;
        logic div_step;
        logic div_store;
        logic commit;
        logic emit;
        job_t job;
    } ftj_cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       held;
        logic       match;
        logic       drag;
        logic       sqrt_last;
        logic       div_last;
        logic       out_free;
    } ftj_status_t;

endpackage

// ----- rtl/ftj_ctrl.sv -----
// ----------------------------------------------------------------------------
// ftj_ctrl
// sequencer that steps the joystick datapath through one event
// ----------------------------------------------------------------------------
module ftj_ctrl
    import ftj_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  ftj_status_t status,
    output ftj_cmd_t    cmd
);

    state_t state_reg, state_next;
    job_t   job_reg, job_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            job_reg   <= JOB_AX;
        end else begin
            state_reg <= state_next;
            job_reg   <= job_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        job_next   = job_reg;
        cmd        = '0;
        cmd.job    = job_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_COORD;
                end
            end
            ST_COORD: begin
                cmd.coord  = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                state_next = ST_DONE;
                case (status.action)
                    ACT_PRESS: cmd.press = !status.held;
                    ACT_MOVE: begin
                        if (status.match) state_next = ST_DIFF;
                    end
                    ACT_RELEASE: cmd.release_src = status.match;
                    default: ;
                endcase
            end
            ST_DIFF: begin
                cmd.diff   = 1'b1;
                state_next = ST_SQX;
            end
            ST_SQX: begin
                cmd.sqx    = 1'b1;
                state_next = ST_SQY;
            end
            ST_SQY: begin
                cmd.sqy    = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                cmd.check  = 1'b1;
                job_next   = JOB_AX;
                state_next = status.drag ? ST_SQRT : ST_DIV_LOAD;
            end
            ST_SQRT: begin
                if (status.sqrt_last) state_next = ST_DIV_LOAD;
                else cmd.sqrt_step = 1'b1;
            end
            ST_DIV_LOAD: begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
                if (status.div_last) begin
                    cmd.div_store = 1'b1;
                    if (job_reg == JOB_OY || (job_reg == JOB_AY && !status.drag)) begin
                        state_next = ST_COMMIT;
                    end else begin
                        job_next   = job_t'(job_reg + 2'd1);
                        state_next = ST_DIV_LOAD;
                    end
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ----- rtl/ftj_datapath.sv -----
// ----------------------------------------------------------------------------
// ftj_datapath
// coordinates, offset, square root and divide unit, stick state and result word
// ----------------------------------------------------------------------------
module ftj_datapath
    import ftj_pkg::*;
#(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
    parameter int ID_WIDTH        = ID_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [1:0]               s_action,
    input  logic                     s_source_kind,
    input  logic [ID_PORT_W-1:0]     s_device_id,
    input  logic [ID_PORT_W-1:0]     s_sub_id,
    input  logic [POS_W-1:0]         s_pos_x,
    input  logic [POS_W-1:0]         s_pos_y,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [AXIS_W-1:0] m_axis_x,
    output logic signed [AXIS_W-1:0] m_axis_y,
    output logic                     m_active,
    output logic                     m_axis_written,
    input  ftj_cmd_t                 cmd,
    output ftj_status_t              status
);

    localparam int F      = COORD_FRAC_BITS;
    localparam int CW     = 14 + F;
    localparam int DW     = CW + 1;
    localparam int SQW    = 2 * DW;
    localparam int RW     = RADIUS_W + F;
    localparam int KW     = (RW > AXIS_BITS) ? RW : AXIS_BITS;
    localparam int QW     = KW;
    localparam int NW     = DW + KW;
    localparam int IDC    = (ID_WIDTH < ID_PORT_W) ? ID_WIDTH : ID_PORT_W;
    localparam int EW     = ((CW > QW + 1) ? CW : QW + 1) + 1;
    localparam int CNTMAX = (DW > QW) ? DW : QW;
    localparam int CNTW   = $clog2(CNTMAX + 1);
    localparam int FPW    = POS_W + FIELD_W;
    localparam int MSW    = POS_W + F;
    localparam int FSH    = POS_W - F;

    localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [MSW-1:0]       MOUSE_MAX = MSW'({(CW-1){1'b1}});

    function automatic logic signed [CW-1:0] coord_of(input logic [POS_W-1:0] pos,
                                                      input logic kind,
                                                      input logic [FIELD_W-1:0] fld);
        logic [FPW-1:0] prod;
        logic [MSW-1:0] sh;
        prod = FPW'(pos) * FPW'(fld);
        sh   = MSW'(pos) << F;
        if (kind == KIND_MOUSE) begin
            coord_of = (sh > MOUSE_MAX) ? COORD_MAX : CW'(sh);
        end else begin
            coord_of = CW'(prod >> FSH);
        end
    endfunction

    function automatic logic signed [CW-1:0] clamp_coord(input logic signed [EW-1:0] v);
        if (v > EW'(COORD_MAX)) clamp_coord = COORD_MAX;
        else if (v < EW'(COORD_MIN)) clamp_coord = COORD_MIN;
        else clamp_coord = CW'(v);
    endfunction

    // configuration
    logic [RADIUS_W-1:0] radius_reg;
    logic [FIELD_W-1:0]  field_w_reg, field_h_reg;

    // captured event
    logic [1:0]            act_reg;
    logic                  kind_reg;
    logic [IDC-1:0]        dev_reg, sub_reg;
    logic [POS_W-1:0]      posx_reg, posy_reg;
    logic signed [CW-1:0]  px_reg, py_reg;

    // stick state
    logic                     held_reg, held_kind_reg, written_reg;
    logic [IDC-1:0]           held_dev_reg, held_sub_reg;
    logic signed [CW-1:0]     cx_reg, cy_reg;
    logic signed [AXIS_W-1:0] ax_last_reg, ay_last_reg;

    // move arithmetic
    logic signed [DW-1:0]     dx_reg, dy_reg;
    logic [RW-1:0]            r_reg;
    logic [SQW-1:0]           acc_reg, rr_reg;
    logic [SQW-1:0]           sq_x_reg, sq_root_reg, sq_bit_reg;
    logic [NW-1:0]            num_reg;
    logic                     neg_reg;
    logic [DW:0]              rem_reg;
    logic [QW-1:0]            quo_reg;
    logic signed [AXIS_W-1:0] ax_res_reg, ay_res_reg;
    logic signed [QW:0]       ox_res_reg, oy_res_reg;
    logic [CNTW-1:0]          cnt_reg;

    logic                     m_valid_reg, m_active_reg, m_written_reg;
    logic signed [AXIS_W-1:0] m_axis_x_reg, m_axis_y_reg;

    logic [DW-1:0]  magx, magy, mag_sel, len, denom;
    logic [SQW-1:0] sqx_prod, sqy_prod, rr_prod, trial;
    logic [KW-1:0]  kmul;
    logic [NW-1:0]  num_prod;
    logic [DW:0]    rem_src, rem2;
    logic [QW-1:0]  q_src;
    logic           ge, drag, job_off, job_y;
    logic signed [QW:0]   qval;
    logic signed [EW-1:0] ex, ey;

    assign magx     = dx_reg[DW-1] ? DW'(-dx_reg) : DW'(dx_reg);
    assign magy     = dy_reg[DW-1] ? DW'(-dy_reg) : DW'(dy_reg);
    assign sqx_prod = SQW'(magx) * SQW'(magx);
    assign sqy_prod = SQW'(magy) * SQW'(magy);
    assign rr_prod  = SQW'(r_reg) * SQW'(r_reg);
    assign drag     = acc_reg > rr_reg;
    assign trial    = sq_root_reg + sq_bit_reg;
    assign len      = sq_root_reg[DW-1:0];
    assign denom    = drag ? len : DW'(r_reg);

    // divide jobs: offset jobs scale by radius, axis jobs by full scale
    assign job_off  = (cmd.job == JOB_OX) || (cmd.job == JOB_OY);
    assign job_y    = (cmd.job == JOB_AY) || (cmd.job == JOB_OY);
    assign mag_sel  = job_y ? magy : magx;
    assign kmul     = job_off ? KW'(r_reg) : KW'(AXIS_FULL);
    assign num_prod = NW'(mag_sel) * NW'(kmul);

    // first step starts from the numerator, later ones from the partial remainder
    assign rem_src = (cnt_reg == '0) ? (DW+1)'(num_reg >> QW) : rem_reg;
    assign q_src   = (cnt_reg == '0) ? num_reg[QW-1:0] : quo_reg;
    assign rem2    = {rem_src[DW-1:0], q_src[QW-1]};
    assign ge      = rem2 >= {1'b0, denom};
    assign qval    = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

    assign ex = EW'(px_reg) - EW'(ox_res_reg);
    assign ey = EW'(py_reg) - EW'(oy_res_reg);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg    <= RADIUS_RESET;
            field_w_reg   <= FIELD_W_RESET;
            field_h_reg   <= FIELD_H_RESET;
            held_reg      <= 1'b0;
            held_kind_reg <= 1'b0;
            held_dev_reg  <= '0;
            held_sub_reg  <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            ax_last_reg   <= '0;
            ay_last_reg   <= '0;
            written_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_RADIUS:  radius_reg  <= cfg_wdata[RADIUS_W-1:0];
                    CFG_FIELD_W: field_w_reg <= cfg_wdata[FIELD_W-1:0];
                    CFG_FIELD_H: field_h_reg <= cfg_wdata[FIELD_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.load) written_reg <= 1'b0;
            if (cmd.press) begin
                held_reg      <= 1'b1;
                held_kind_reg <= kind_reg;
                held_dev_reg  <= dev_reg;
                held_sub_reg  <= sub_reg;
                cx_reg        <= px_reg;
                cy_reg        <= py_reg;
                ax_last_reg   <= '0;
                ay_last_reg   <= '0;
                written_reg   <= 1'b1;
            end
            if (cmd.release_src) begin
                held_reg    <= 1'b0;
                ax_last_reg <= '0;
                ay_last_reg <= '0;
                written_reg <= 1'b1;
            end
            if (cmd.commit) begin
                ax_last_reg <= ax_res_reg;
                ay_last_reg <= ay_res_reg;
                written_reg <= 1'b1;
                if (drag) begin
                    cx_reg <= clamp_coord(ex);
                    cy_reg <= clamp_coord(ey);
                end
            end
            if (cmd.check || cmd.div_load) cnt_reg <= '0;
            else if (cmd.sqrt_step || cmd.div_step) cnt_reg <= cnt_reg + 1'b1;
            if (cmd.emit) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg  <= s_action;
            kind_reg <= s_source_kind;
            dev_reg  <= s_device_id[IDC-1:0];
            sub_reg  <= s_sub_id[IDC-1:0];
            posx_reg <= s_pos_x;
            posy_reg <= s_pos_y;
        end
        if (cmd.coord) begin
            px_reg <= coord_of(posx_reg, kind_reg, field_w_reg);
            py_reg <= coord_of(posy_reg, kind_reg, field_h_reg);
        end
        if (cmd.diff) begin
            dx_reg <= DW'(px_reg) - DW'(cx_reg);
            dy_reg <= DW'(py_reg) - DW'(cy_reg);
            r_reg  <= RW'((radius_reg == '0) ? RADIUS_W'(1) : radius_reg) << F;
        end
        if (cmd.sqx) acc_reg <= sqx_prod;
        if (cmd.sqy) begin
            acc_reg <= acc_reg + sqy_prod;
            rr_reg  <= rr_prod;
        end
        if (cmd.check) begin
            sq_x_reg    <= acc_reg;
            sq_root_reg <= '0;
            sq_bit_reg  <= SQW'(1) << (2 * (DW - 1));
        end
        if (cmd.sqrt_step) begin
            if (sq_x_reg >= trial) begin
                sq_x_reg    <= sq_x_reg - trial;
                sq_root_reg <= (sq_root_reg >> 1) + sq_bit_reg;
            end else begin
                sq_root_reg <= sq_root_reg >> 1;
            end
            sq_bit_reg <= sq_bit_reg >> 2;
        end
        if (cmd.div_load) begin
            num_reg <= num_prod;
            neg_reg <= job_y ? dy_reg[DW-1] : dx_reg[DW-1];
        end
        if (cmd.div_step) begin
            rem_reg <= ge ? rem2 - {1'b0, denom} : rem2;
            quo_reg <= {q_src[QW-2:0], ge};
        end
        if (cmd.div_store) begin
            case (cmd.job)
                JOB_AX:  ax_res_reg <= AXIS_W'(qval);
                JOB_AY:  ay_res_reg <= AXIS_W'(qval);
                JOB_OX:  ox_res_reg <= qval;
                default: oy_res_reg <= qval;
            endcase
        end
        if (cmd.emit) begin
            m_axis_x_reg  <= ax_last_reg;
            m_axis_y_reg  <= ay_last_reg;
            m_active_reg  <= held_reg;
            m_written_reg <= written_reg;
        end
    end

    always_comb begin
        status           = '0;
        status.action    = act_reg;
        status.held      = held_reg;
        status.match     = held_reg && (held_kind_reg == kind_reg) &&
                           (held_dev_reg == dev_reg) &&
                           ((held_sub_reg == sub_reg) ||
                            (kind_reg == KIND_MOUSE && act_reg == ACT_MOVE));
        status.drag      = drag;
        status.sqrt_last = (cnt_reg == CNTW'(DW));
        status.div_last  = (cnt_reg == CNTW'(QW));
        status.out_free  = !m_valid_reg || m_ready;
    end

    assign m_valid        = m_valid_reg;
    assign m_axis_x       = m_axis_x_reg;
    assign m_axis_y       = m_axis_y_reg;
    assign m_active       = m_active_reg;
    assign m_axis_written = m_written_reg;

endmodule

// ----- rtl/floating_touch_joystick_top.sv -----
// ----------------------------------------------------------------------------
// floating_touch_joystick_top
// pointer events in, two-axis virtual joystick word out
// ----------------------------------------------------------------------------
// latency path: presses, releases and ignored events pass coord, decide, done;
//   moves in the radius add diff, sqx, sqy, check, axis divides and commit,
//   and a drag adds the square root first and the two offset divides last
// throughput: one event at a time, set by the bit-serial root and divider; the
//   next is taken once the word is parked in the output register
// reset: synchronous, active low; stick idle, axes zero, registers 80/320/480
module floating_touch_joystick_top
    import ftj_pkg::*;
#(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
    parameter int ID_WIDTH        = ID_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration writes
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_wdata,
    // pointer event words
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_action,
    input  logic                     s_source_kind,
    input  logic [ID_PORT_W-1:0]     s_device_id,
    input  logic [ID_PORT_W-1:0]     s_sub_id,
    input  logic [POS_W-1:0]         s_pos_x,
    input  logic [POS_W-1:0]         s_pos_y,
    // joystick result words
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [AXIS_W-1:0] m_axis_x,
    output logic signed [AXIS_W-1:0] m_axis_y,
    output logic                     m_active,
    output logic                     m_axis_written
);

    ftj_cmd_t    cmd;
    ftj_status_t status;

    // sequencer: one state per datapath step, divider and root loop counted
    // in the datapath
    ftj_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // arithmetic, stick state, configuration and output register
    ftj_datapath #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .ID_WIDTH        (ID_WIDTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_action       (s_action),
        .s_source_kind  (s_source_kind),
        .s_device_id    (s_device_id),
        .s_sub_id       (s_sub_id),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_axis_x       (m_axis_x),
        .m_axis_y       (m_axis_y),
        .m_active       (m_active),
        .m_axis_written (m_axis_written),
        .cmd            (cmd),
        .status         (status)
    );

    // an idle stick always reports centered axes
    a_idle_centered: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_active) |-> (m_axis_x == '0 && m_axis_y == '0))
        else $error("idle stick reports nonzero axes");

    // axes never reach the most negative code
    a_axis_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_axis_x != AXIS_W'(-AXIS_FULL - 1) &&
                     m_axis_y != AXIS_W'(-AXIS_FULL - 1)))
        else $error("axis out of range");

    // an accepted word keeps the sequencer busy for the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken again right after accept");

    // a result is only loaded when the output register is free
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid || m_ready))
        else $error("result word overwritten");

endmodule
